// ===== src/skf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and microcode program of the scalar Kalman filter.
// No dependencies; imported by the sequencer, the datapath and the top level.
package skf_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd3;

  // Register reset values
  localparam int unsigned RST_INIT_COV   = 65536;
  localparam int unsigned RST_PROC_NOISE = 655;
  localparam int unsigned RST_MEAS_NOISE = 6554;

  // Datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_IDLE   = 3'd0;
  localparam logic [OP_W-1:0] OP_PRED   = 3'd1;
  localparam logic [OP_W-1:0] OP_DENOM  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV0   = 3'd3;
  localparam logic [OP_W-1:0] OP_DIVN   = 3'd4;
  localparam logic [OP_W-1:0] OP_MINIT  = 3'd5;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd6;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd7;

  // Sequencing conditions
  localparam logic [1:0] CND_NEXT     = 2'd0;
  localparam logic [1:0] CND_WAIT_IN  = 2'd1;
  localparam logic [1:0] CND_LOOP     = 2'd2;
  localparam logic [1:0] CND_WAIT_OUT = 2'd3;

  // Loop counter loads
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_DIV  = 2'd1;
  localparam logic [1:0] CNT_MUL  = 2'd2;

  localparam int STEP_W = 3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [1:0]        cond;
    logic [1:0]        cnt_ld;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            go;
  } ctrl_t;

  // Microcode program, one control word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_IDLE, cond: CND_WAIT_IN, cnt_ld: CNT_NONE, target: 3'd0};
    unique case (step)
      3'd0: w = '{op: OP_IDLE,   cond: CND_WAIT_IN,  cnt_ld: CNT_NONE, target: 3'd0};
      3'd1: w = '{op: OP_PRED,   cond: CND_NEXT,     cnt_ld: CNT_NONE, target: 3'd0};
      3'd2: w = '{op: OP_DENOM,  cond: CND_NEXT,     cnt_ld: CNT_NONE, target: 3'd0};
      3'd3: w = '{op: OP_DIV0,   cond: CND_NEXT,     cnt_ld: CNT_DIV,  target: 3'd0};
      3'd4: w = '{op: OP_DIVN,   cond: CND_LOOP,     cnt_ld: CNT_NONE, target: 3'd4};
      3'd5: w = '{op: OP_MINIT,  cond: CND_NEXT,     cnt_ld: CNT_MUL,  target: 3'd0};
      3'd6: w = '{op: OP_MUL,    cond: CND_LOOP,     cnt_ld: CNT_NONE, target: 3'd6};
      3'd7: w = '{op: OP_UPDATE, cond: CND_WAIT_OUT, cnt_ld: CNT_NONE, target: 3'd0};
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ===== src/scalar_kalman_filter_top.sv =====
`timescale 1ns / 1ps
// Top level of the scalar Kalman filter: configuration registers, output
// register and assertions. Depends on skf_pkg, skf_sequencer, skf_datapath.

// Scalar random-walk Kalman filter in fixed point (DATA_WIDTH bits, FRAC_BITS
// fraction bits). Each request on the in_ channel carries one signed
// measurement; the block answers with one out_ request holding the updated
// estimate. A small microcode program steps a shared datapath: predict, form
// the denominator, run a restoring divider for the gain (FRAC_BITS+1 steps),
// then a shift-add loop that forms both gain products at once (FRAC_BITS+1
// steps). The next request is taken as soon as the program returns to its
// idle step, even while the previous result still waits in the output
// register; the update step then holds until that result is taken. Any write
// to one of the four configuration registers reloads the estimate and
// covariance from the initial registers; write only while idle.
module scalar_kalman_filter_top
  import skf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_measurement,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_filtered_value,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_data
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] init_est_r, init_cov_r, proc_noise_r, meas_noise_r;
  logic [W-1:0] reload_est, reload_cov, result;
  logic         reload;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_value_r;
  logic         out_free, upd_go;
  ctrl_t        ctrl;

  // Configuration: store the write, and reload the state with the new value
  // bypassed in so the reload sees the register as written.
  always_comb begin
    reload     = 1'b0;
    reload_est = init_est_r;
    reload_cov = init_cov_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_EST: begin
          reload     = 1'b1;
          reload_est = cfg_data;
        end
        REG_INIT_COV: begin
          reload     = 1'b1;
          reload_cov = cfg_data;
        end
        REG_PROC_NOISE, REG_MEAS_NOISE: reload = 1'b1;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_est_r   <= '0;
      init_cov_r   <= W'(RST_INIT_COV);
      proc_noise_r <= W'(RST_PROC_NOISE);
      meas_noise_r <= W'(RST_MEAS_NOISE);
    end else if (cfg_we) begin
      if (cfg_index == REG_INIT_EST)   init_est_r   <= cfg_data;
      if (cfg_index == REG_INIT_COV)   init_cov_r   <= cfg_data;
      if (cfg_index == REG_PROC_NOISE) proc_noise_r <= cfg_data;
      if (cfg_index == REG_MEAS_NOISE) meas_noise_r <= cfg_data;
    end
  end

  // Output register: the update step waits here until the slot is free.
  assign out_free = !out_valid_r || out_ready;

  skf_sequencer #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  skf_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .reload        (reload),
    .reload_est    (reload_est),
    .reload_cov    (reload_cov),
    .process_noise (proc_noise_r),
    .meas_noise    (meas_noise_r),
    .measurement   (in_measurement),
    .result        (result)
  );

  assign upd_go = (ctrl.op == OP_UPDATE) && ctrl.go;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (upd_go)    out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (upd_go) out_value_r <= result;
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

  // An accepted request puts the sequencer to work: no second accept follows.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after an accept");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending result");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

// ===== src/skf_sequencer.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, loop counter and conditional jumps.
// Depends on skf_pkg for the program table and the control codes.
module skf_sequencer
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_free,
  output logic  in_ready,
  output ctrl_t ctrl
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  uword_t            uw;
  logic              go;

  assign uw = ucode(pc_r);

  always_comb begin
    go      = 1'b1;
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    unique case (uw.cond)
      CND_NEXT: begin
        pc_nxt = STEP_W'(pc_r + 1'b1);
      end
      CND_WAIT_IN: begin
        go = in_valid;
        if (go) pc_nxt = STEP_W'(pc_r + 1'b1);
      end
      CND_LOOP: begin
        if (cnt_r != '0) begin
          cnt_nxt = CNT_W'(cnt_r - 1'b1);
          pc_nxt  = uw.target;
        end else begin
          pc_nxt = STEP_W'(pc_r + 1'b1);
        end
      end
      CND_WAIT_OUT: begin
        go = out_free;
        if (go) pc_nxt = uw.target;
      end
      default: ;
    endcase
    // loop counts: the loop step runs count+1 times
    if (go && uw.cnt_ld == CNT_DIV) cnt_nxt = CNT_W'(FRAC_BITS - 1);
    if (go && uw.cnt_ld == CNT_MUL) cnt_nxt = CNT_W'(FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign in_ready = (uw.cond == CND_WAIT_IN);
  assign ctrl.op  = uw.op;
  assign ctrl.go  = go;

endmodule

// ===== src/skf_datapath.sv =====
`timescale 1ns / 1ps
// Filter datapath: prediction, restoring gain divider, shift-add multipliers
// and the state update. Depends on skf_pkg; driven by skf_sequencer.
module skf_datapath
  import skf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl,
  input  logic                  reload,
  input  logic [DATA_WIDTH-1:0] reload_est,
  input  logic [DATA_WIDTH-1:0] reload_cov,
  input  logic [DATA_WIDTH-1:0] process_noise,
  input  logic [DATA_WIDTH-1:0] meas_noise,
  input  logic [DATA_WIDTH-1:0] measurement,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = W + F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [W-1:0]  est_r, cov_r, z_r, p_r;
  logic [W:0]    innov_r, den_r, rem_r, mag_r;
  logic          neg_r;
  logic [F:0]    q_r, ga_r, gb_r;
  logic [AW-1:0] acc_a_r, acc_b_r;

  logic [W:0]    psum, dsum, innov_c;
  logic [W-1:0]  p_sat;
  logic [W+1:0]  trial, dsub;
  logic          qbit;
  logic [W+1:0]  delta, est_ext, sum;

  assign psum    = {1'b0, cov_r} + {1'b0, process_noise};
  assign p_sat   = psum[W] ? {W{1'b1}} : psum[W-1:0];
  assign innov_c = {z_r[W-1], z_r} - {est_r[W-1], est_r};
  assign dsum    = {1'b0, p_r} + {1'b0, meas_noise};

  // first divider step compares without shifting
  assign trial = (ctrl.op == OP_DIV0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign dsub  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r}) && (den_r != '0);

  assign delta   = acc_a_r[W+F+1:F];
  assign est_ext = {{2{est_r[W-1]}}, est_r};
  assign sum     = neg_r ? (est_ext - delta) : (est_ext + delta);

  // clamp to the signed range
  always_comb begin
    if (sum[W+1] == sum[W] && sum[W] == sum[W-1]) result = sum[W-1:0];
    else if (sum[W+1])                              result = {1'b1, {(W-1){1'b0}}};
    else                                            result = {1'b0, {(W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      cov_r <= W'(RST_INIT_COV);
    end else if (reload) begin
      est_r <= reload_est;
      cov_r <= reload_cov;
    end else if (ctrl.op == OP_UPDATE && ctrl.go) begin
      est_r <= result;
      cov_r <= acc_b_r[W+F-1:F];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: begin
        if (ctrl.go) z_r <= measurement;
      end
      OP_PRED: begin
        p_r     <= p_sat;
        innov_r <= innov_c;
      end
      OP_DENOM: begin
        den_r <= dsum;
        rem_r <= {1'b0, p_r};
        q_r   <= '0;
        neg_r <= innov_r[W];
        mag_r <= innov_r[W] ? (W+1)'(-innov_r) : innov_r;
      end
      OP_DIV0, OP_DIVN: begin
        rem_r <= qbit ? dsub[W:0] : trial[W:0];
        q_r   <= {q_r[F-1:0], qbit};
      end
      OP_MINIT: begin
        ga_r    <= q_r;
        gb_r    <= ONE - q_r;
        acc_a_r <= '0;
        acc_b_r <= '0;
      end
      OP_MUL: begin
        acc_a_r <= {acc_a_r[AW-2:0], 1'b0} + (ga_r[F] ? {{(F+1){1'b0}}, mag_r} : '0);
        acc_b_r <= {acc_b_r[AW-2:0], 1'b0} + (gb_r[F] ? {{(F+2){1'b0}}, p_r} : '0);
        ga_r    <= {ga_r[F-1:0], 1'b0};
        gb_r    <= {gb_r[F-1:0], 1'b0};
      end
      default: ;
    endcase
  end

endmodule
